[rtl/mpq_pkg.sv]
// shared constants, types and codes of the priority queue
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int OCC_W    = $clog2(CAPACITY + 1);
  localparam int CNT_W    = IDX_W + 2;

  localparam int PRIO_W   = 4;
  localparam int AGE_W    = 8;
  localparam int TAG_W    = 64;
  localparam int ENT_W    = PRIO_W + AGE_W + TAG_W;
  localparam int TDATA_W  = ((ENT_W + 7) / 8) * 8;
  localparam int STAT_W   = 2;

  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int QCNT_W   = $clog2(QDEPTH + 1);

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_EXTRACT = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_EXTRACTED = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  // prio in the lowest bits, tag in the highest
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   func;
    entry_t ent;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT,
    S_DONE
  } back_state_t;

endpackage

[rtl/mpq_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module mpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/mpq_front.sv]
// input side: decodes words and holds them in a short queue for the back end
`timescale 1ns / 1ps

module mpq_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mpq_pkg::TDATA_W-1:0]  in_tdata,   // prio, age, tag, zero pad
  input  logic [0:0]                   in_tuser,   // func
  input  logic                         q_pop,
  output mpq_pkg::q_head_t             q_head
);
  import mpq_pkg::*;

  item_t             buf_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push, pop;
  item_t             in_item;

  always_comb begin
    in_item.func = in_tuser[0];
    in_item.ent  = in_tdata[ENT_W-1:0];
  end

  assign in_tready = (cnt_r != QCNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= in_item;
    end
  end

  always_comb begin
    q_head.valid = (cnt_r != '0);
    q_head.item  = buf_r[rd_ptr_r];
  end

endmodule

[rtl/mpq_back.sv]
// execution side: insert, max scan with compaction, result register
`timescale 1ns / 1ps

module mpq_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpq_pkg::q_head_t             q_head,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mpq_pkg::TDATA_W-1:0]  out_tdata,  // prio, age, tag, zero pad
  output logic [mpq_pkg::STAT_W-1:0]   out_tuser   // status
);
  import mpq_pkg::*;

  back_state_t      state_r, state_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] chk_r, chk_nxt;
  logic [CNT_W-1:0] best_idx_r, best_idx_nxt;
  entry_t           best_ent_r, best_ent_nxt;
  logic [CNT_W-1:0] sh_idx_r, sh_idx_nxt;

  logic             out_tvalid_r;
  status_t          out_status_r;
  entry_t           out_ent_r;

  logic             out_free;
  logic             out_load;
  status_t          load_status;
  entry_t           load_ent;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           rd_ent;

  logic [CNT_W-1:0] occ_c, occ_m1, sh_p1, sh_p2, new_best;
  logic             take;

  mpq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent   = ram_rdata;
  assign out_free = !out_tvalid_r || out_tready;
  assign occ_c    = CNT_W'(occ_r);
  assign occ_m1   = occ_c - CNT_W'(1);
  assign sh_p1    = sh_idx_r + CNT_W'(1);
  assign sh_p2    = sh_idx_r + CNT_W'(2);
  // strict greater keeps the oldest among equal maxima
  assign take     = (chk_r == '0) || (rd_ent.prio > best_ent_r.prio);
  assign new_best = take ? chk_r : best_idx_r;

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    rd_idx_nxt   = rd_idx_r;
    chk_nxt      = chk_r;
    best_idx_nxt = best_idx_r;
    best_ent_nxt = best_ent_r;
    sh_idx_nxt   = sh_idx_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = '0;
    out_load     = 1'b0;
    load_status  = STAT_INSERTED;
    load_ent     = '0;

    case (state_r)
      S_IDLE: begin
        if (q_head.valid && out_free) begin
          q_pop = 1'b1;
          if (q_head.item.func == FUNC_INSERT) begin
            out_load = 1'b1;
            if (occ_r == OCC_W'(CAPACITY)) begin
              load_status = STAT_FULL;
            end else begin
              ram_we      = 1'b1;
              ram_waddr   = occ_r[IDX_W-1:0];
              ram_wdata   = q_head.item.ent;
              occ_nxt     = occ_r + OCC_W'(1);
              load_status = STAT_INSERTED;
            end
          end else if (occ_r == '0) begin
            out_load    = 1'b1;
            load_status = STAT_EMPTY;
          end else begin
            ram_raddr  = '0;
            rd_idx_nxt = CNT_W'(1);
            chk_nxt    = '0;
            state_nxt  = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (take) begin
          best_ent_nxt = rd_ent;
          best_idx_nxt = chk_r;
        end
        if (rd_idx_r < occ_c) begin
          ram_raddr = rd_idx_r[IDX_W-1:0];
        end
        rd_idx_nxt = rd_idx_r + CNT_W'(1);
        chk_nxt    = chk_r + CNT_W'(1);
        if (chk_r == occ_m1) begin
          if (new_best == occ_m1) begin
            state_nxt = S_DONE;
          end else begin
            sh_idx_nxt = new_best;
            state_nxt  = S_SHIFT_RD;
          end
        end
      end

      S_SHIFT_RD: begin
        ram_raddr = sh_p1[IDX_W-1:0];
        state_nxt = S_SHIFT;
      end

      S_SHIFT: begin
        // move slot i+1 down to slot i, read i+2 meanwhile
        ram_we    = 1'b1;
        ram_waddr = sh_idx_r[IDX_W-1:0];
        ram_wdata = rd_ent;
        if (sh_p2 == occ_c) begin
          state_nxt = S_DONE;
        end else begin
          ram_raddr  = sh_p2[IDX_W-1:0];
          sh_idx_nxt = sh_p1;
        end
      end

      S_DONE: begin
        out_load    = 1'b1;
        load_status = STAT_EXTRACTED;
        load_ent    = best_ent_r;
        occ_nxt     = occ_r - OCC_W'(1);
        state_nxt   = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r   <= rd_idx_nxt;
    chk_r      <= chk_nxt;
    best_idx_r <= best_idx_nxt;
    best_ent_r <= best_ent_nxt;
    sh_idx_r   <= sh_idx_nxt;
    if (out_load) begin
      out_status_r <= load_status;
      out_ent_r    <= load_ent;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = TDATA_W'(out_ent_r);
  assign out_tuser  = out_status_r;

endmodule

[rtl/max_priority_queue.sv]
// top level of the bounded max priority queue
// sequence: insert, full and empty words are answered from the idle state into the result register;
//   an extract runs a pop step, a scan of all entries, a compaction unless the max is the youngest
//   entry, and a result step, paced by the single read port of the store
// throughput: one word at a time in the back end; a two-word queue keeps accepting
// reset: rst_n synchronous active low clears occupancy, queue and result valid;
//   store contents are not cleared and are never used above occupancy
`timescale 1ns / 1ps

module max_priority_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  // input words
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mpq_pkg::TDATA_W-1:0]  in_tdata,   // priority_req[3:0], age[11:4], patient_tag[75:12]
  input  logic [0:0]                   in_tuser,   // func: insert or extract
  // result words
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mpq_pkg::TDATA_W-1:0]  out_tdata,  // out_priority[3:0], out_age[11:4], out_tag[75:12]
  output logic [mpq_pkg::STAT_W-1:0]   out_tuser   // status
);
  import mpq_pkg::*;

  // head of the word queue between front and back
  q_head_t q_head;
  logic    q_pop;

  // front: takes words off the bus, splits func from the entry fields
  mpq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  // back: entries kept in insertion order, extract scans for the max then
  // shifts the younger entries down one slot
  mpq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/mpq_checker.sv]
// port level checks for the priority queue, bound to the top level
`timescale 1ns / 1ps

module mpq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [mpq_pkg::TDATA_W-1:0]  out_tdata,
  input logic [mpq_pkg::STAT_W-1:0]   out_tuser
);
  import mpq_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // only an extracted result carries entry fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != STAT_EXTRACTED) |-> out_tdata == '0)
    else $error("non-extract result with nonzero fields");

  // reset leaves no result pending and the queue open
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (.*);

[tb/tb_top.sv]
// self-checking bench for the bounded max priority queue: directed table then random phases
`timescale 1ns / 1ps

module tb_top;
  import mpq_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int LONG_HOLD    = 300;     // receiver hold-off long enough to back up the input
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;  // drain margin for a worst-case extract
  localparam int CYCLE_LIMIT  = 400000;

  // one expected result word, field by field
  typedef struct packed {
    status_t           status;
    logic [PRIO_W-1:0] prio;
    logic [AGE_W-1:0]  age;
    logic [TAG_W-1:0]  tag;
  } qresult_t;

  // one row of the directed table; typed rows carry their status, value fields are zero
  typedef struct {
    logic              func;
    logic [PRIO_W-1:0] prio;
    logic [AGE_W-1:0]  age;
    logic [TAG_W-1:0]  tag;
    bit                typed;
    status_t           typed_status;
  } stim_row_t;

  // random phase shapes: fill up, drain down, balanced, and heavy on equal priorities
  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIXED,
    PH_TIES
  } phase_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic [0:0]         in_tuser = FUNC_INSERT;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]  out_tuser;

  // shadow of the queue contents, kept in insertion order like the block
  logic [PRIO_W-1:0]  held_prio [CAPACITY];
  logic [AGE_W-1:0]   held_age  [CAPACITY];
  logic [TAG_W-1:0]   held_tag  [CAPACITY];
  int                 held_count = 0;

  qresult_t           awaited_results [$];
  stim_row_t          directed_rows [$];
  int                 mismatches = 0;
  int                 cycle_count = 0;
  bit                 idle_on = 1'b1;      // both sides may insert gaps
  bit                 hold_request = 1'b0; // sender asks the receiver for the long hold-off
  int                 rx_stall_left = 0;

  max_priority_queue uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gap length: mostly none or short, now and then long; none at all in quiet phases
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!idle_on || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // tags: the all-zero and all-one extremes, walking single bits, and full random
  function automatic logic [TAG_W-1:0] draw_tag();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, TAG_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // applies one word to the shadow queue and returns the result the block owes for it
  function automatic qresult_t predict_queue_op(input logic func,
                                                input logic [PRIO_W-1:0] prio,
                                                input logic [AGE_W-1:0] age,
                                                input logic [TAG_W-1:0] tag);
    qresult_t r;
    int       best;
    r.status = STAT_INSERTED;
    r.prio   = '0;
    r.age    = '0;
    r.tag    = '0;
    if (func == FUNC_INSERT) begin
      if (held_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        held_prio[held_count] = prio;
        held_age[held_count]  = age;
        held_tag[held_count]  = tag;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      // strict compare keeps the oldest among equal maxima
      best = 0;
      for (int i = 1; i < held_count; i++) begin
        if (held_prio[i] > held_prio[best]) best = i;
      end
      r.status = STAT_EXTRACTED;
      r.prio   = held_prio[best];
      r.age    = held_age[best];
      r.tag    = held_tag[best];
      for (int i = best; i + 1 < held_count; i++) begin
        held_prio[i] = held_prio[i + 1];
        held_age[i]  = held_age[i + 1];
        held_tag[i]  = held_tag[i + 1];
      end
      held_count--;
    end
    return r;
  endfunction

  task automatic add_row(input logic func, input logic [PRIO_W-1:0] prio,
                         input logic [AGE_W-1:0] age, input logic [TAG_W-1:0] tag,
                         input bit typed, input status_t typed_status);
    stim_row_t row;
    row.func         = func;
    row.prio         = prio;
    row.age          = age;
    row.tag          = tag;
    row.typed        = typed;
    row.typed_status = typed_status;
    directed_rows.push_back(row);
  endtask

  // drives one word after a random gap, waits for the handshake, queues its expectation
  task automatic send_word(input logic func, input logic [PRIO_W-1:0] prio,
                           input logic [AGE_W-1:0] age, input logic [TAG_W-1:0] tag,
                           input bit typed, input status_t typed_status);
    int       gap;
    qresult_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser = func;
    in_tdata = '0;
    in_tdata[PRIO_W-1:0]                       = prio;
    in_tdata[PRIO_W+AGE_W-1:PRIO_W]            = age;
    in_tdata[PRIO_W+AGE_W+TAG_W-1:PRIO_W+AGE_W] = tag;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // word taken at this edge: the shadow moves on even for rows with a typed answer
    predicted = predict_queue_op(func, prio, age, tag);
    if (typed) begin
      predicted.status = typed_status;
      predicted.prio   = '0;
      predicted.age    = '0;
      predicted.tag    = '0;
    end
    awaited_results.push_back(predicted);
  endtask

  task automatic check_field(input string what, input logic [TAG_W-1:0] want,
                             input logic [TAG_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls, plus the one long hold-off that backs the block up
  always @(negedge clk) begin
    if (hold_request) begin
      rx_stall_left = LONG_HOLD;
      hold_request  = 1'b0;
    end
    if (rx_stall_left > 0) begin
      out_tready = 1'b0;
      rx_stall_left--;
    end else begin
      rx_stall_left = pick_gap();
      out_tready    = (rx_stall_left == 0);
    end
  end

  // result checker: every accepted word against the oldest expectation
  always @(posedge clk) begin
    qresult_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d tdata 0x%0h",
                 $time, out_tuser, out_tdata);
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("priority", want.prio, out_tdata[PRIO_W-1:0]);
        check_field("age", want.age, out_tdata[PRIO_W+AGE_W-1:PRIO_W]);
        check_field("tag", want.tag, out_tdata[PRIO_W+AGE_W+TAG_W-1:PRIO_W+AGE_W]);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
    $display("FAIL max_priority_queue");
    $finish;
  end

  initial begin
    phase_t            phase_kind;
    int                phase_len;
    int                insert_pct;
    int                sent;
    bit                hold_done;
    logic              func;
    logic [PRIO_W-1:0] prio;

    // directed table
    // empty extract, the field extremes, a tie at the top priority, then draining to empty
    add_row(FUNC_EXTRACT, 4'd0,  8'd0,   64'd0, 1'b1, STAT_EMPTY);
    add_row(FUNC_INSERT,  4'd0,  8'd0,   64'd0, 1'b1, STAT_INSERTED);
    add_row(FUNC_INSERT,  4'd15, 8'd255, '1,    1'b1, STAT_INSERTED);
    add_row(FUNC_INSERT,  4'd15, 8'd1,   64'd1, 1'b1, STAT_INSERTED);
    add_row(FUNC_EXTRACT, 4'd0,  8'd0,   64'd0, 1'b0, STAT_EXTRACTED); // older of the tie
    add_row(FUNC_EXTRACT, 4'd0,  8'd0,   64'd0, 1'b0, STAT_EXTRACTED);
    add_row(FUNC_EXTRACT, 4'd0,  8'd0,   64'd0, 1'b0, STAT_EXTRACTED);
    add_row(FUNC_EXTRACT, 4'd15, 8'd255, '1,    1'b1, STAT_EMPTY);
    // fill to capacity, then an insert that must be dropped, then one extract from full
    for (int i = 0; i < CAPACITY; i++) begin
      add_row(FUNC_INSERT, 4'((i * 7) % 16), 8'(i * 16 + 1),
              64'h0123_4567_89ab_cdef ^ (64'd1 << (i * 4)), 1'b1, STAT_INSERTED);
    end
    add_row(FUNC_INSERT,  4'd15, 8'd255, '1,    1'b1, STAT_FULL);
    add_row(FUNC_EXTRACT, 4'd0,  8'd0,   64'd0, 1'b0, STAT_EXTRACTED);

    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].func, directed_rows[i].prio, directed_rows[i].age,
                directed_rows[i].tag, directed_rows[i].typed, directed_rows[i].typed_status);
    end

    // random phases, each with its own mix of inserts and extracts
    sent      = 0;
    hold_done = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      phase_kind = phase_t'($urandom_range(0, 3));
      phase_len  = $urandom_range(8, 40);
      idle_on    = ($urandom_range(0, 3) != 0);
      if (!hold_done && sent >= 150) begin
        // receiver holds off while the sender keeps offering back to back
        hold_done    = 1'b1;
        hold_request = 1'b1;
        idle_on      = 1'b0;
        phase_kind   = PH_MIXED;
        phase_len    = 30;
      end
      case (phase_kind)
        PH_FILL:  insert_pct = 85;
        PH_DRAIN: insert_pct = 15;
        default:  insert_pct = 50;
      endcase
      for (int k = 0; k < phase_len; k++) begin
        func = ($urandom_range(0, 99) < insert_pct) ? FUNC_INSERT : FUNC_EXTRACT;
        if (phase_kind == PH_TIES) begin
          // four levels in two neighboring pairs, so many entries share the maximum
          prio = 4'($urandom_range(0, 1) + ($urandom_range(0, 1) ? 14 : 0));
        end else begin
          prio = 4'($urandom_range(0, 15));
        end
        send_word(func, prio, 8'($urandom_range(0, 255)), draw_tag(), 1'b0, STAT_INSERTED);
        sent++;
      end
    end
    idle_on = 1'b1;
    @(negedge clk);
    in_tvalid = 1'b0;

    // drain: every word owes one result, then allow a worst-case extract for stragglers
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS max_priority_queue");
    end else begin
      $display("FAIL max_priority_queue");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mpq_pkg.sv
rtl/mpq_ram.sv
rtl/mpq_front.sv
rtl/mpq_back.sv
rtl/max_priority_queue.sv
rtl/mpq_checker.sv
tb/tb_top.sv
